[rtl/core/four_light_normal_pixel_macros.svh]
// assertion macros for the four-light normal block
// used by rtl/core/four_light_normal_pixel.sv, no other dependencies
`ifndef FOUR_LIGHT_NORMAL_PIXEL_MACROS_SVH
`define FOUR_LIGHT_NORMAL_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold in the same cycle as the trigger
`define FLN_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle implication");

// condition must hold in the cycle after the trigger
`define FLN_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle implication");

`else

`define FLN_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define FLN_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

[rtl/core/fln_pkg.sv]
// shared types, constants and helpers for the four-light normal block
// no dependencies
package fln_pkg;

  localparam int PIX_W         = 24;
  localparam int BYTE_W        = 8;
  localparam int DIFF_W        = 9;
  localparam int SQ_W          = 16;
  localparam int SUM_W         = 17;
  localparam int OUT_W         = 16;
  localparam int FRAC_BITS_DEF = 14;

  typedef struct packed {
    logic [PIX_W-1:0] north_pixel;
    logic [PIX_W-1:0] east_pixel;
    logic [PIX_W-1:0] south_pixel;
    logic [PIX_W-1:0] west_pixel;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic                    degenerate;
  } out_t;

  // sideband that rides along the cell chain
  typedef struct packed {
    logic degen;
    logic neg_x;
    logic neg_y;
  } side_t;

  function automatic logic [BYTE_W-1:0] max3(input logic [PIX_W-1:0] p);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] m;
    a = p[BYTE_W-1:0];
    b = p[2*BYTE_W-1:BYTE_W];
    c = p[3*BYTE_W-1:2*BYTE_W];
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

endpackage

[rtl/core/fln_front.sv]
// input stage: channel maxima, differences, squares and their sum
// depends on fln_pkg
module fln_front import fln_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      valid_i,
  input  in_t                       data_i,
  output logic                      valid_o,
  output side_t                     side_o,
  output logic [SUM_W-1:0]          s_o,
  output logic [1:0][SQ_W-1:0]      sq_o
);

  logic [BYTE_W-1:0]        n_max;
  logic [BYTE_W-1:0]        e_max;
  logic [BYTE_W-1:0]        s_max;
  logic [BYTE_W-1:0]        w_max;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        mag_x;
  logic [DIFF_W-1:0]        mag_y;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  logic [SUM_W-1:0]         sum;

  logic                     valid_r;
  side_t                    side_r;
  side_t                    side_nxt;
  logic [SUM_W-1:0]         s_r;
  logic [1:0][SQ_W-1:0]     sq_r;

  assign n_max = max3(data_i.north_pixel);
  assign e_max = max3(data_i.east_pixel);
  assign s_max = max3(data_i.south_pixel);
  assign w_max = max3(data_i.west_pixel);

  assign dx = $signed({1'b0, e_max}) - $signed({1'b0, w_max});
  assign dy = $signed({1'b0, n_max}) - $signed({1'b0, s_max});

  assign mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  // magnitudes are at most 255, so the low byte carries them
  assign sq_x = SQ_W'(mag_x[BYTE_W-1:0] * mag_x[BYTE_W-1:0]);
  assign sq_y = SQ_W'(mag_y[BYTE_W-1:0] * mag_y[BYTE_W-1:0]);
  assign sum  = SUM_W'(sq_x) + SUM_W'(sq_y);

  always_comb begin
    side_nxt.degen = (sum == '0);
    side_nxt.neg_x = dx[DIFF_W-1];
    side_nxt.neg_y = dy[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r   <= side_nxt;
      s_r      <= sum;
      sq_r[0]  <= sq_x;
      sq_r[1]  <= sq_y;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign s_o     = s_r;
  assign sq_o    = sq_r;

endmodule

[rtl/core/fln_cell.sv]
// one cell of the root-search chain: settles one bit of the doubled scaled magnitude
// for both lanes; depends on fln_pkg
module fln_cell import fln_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  parameter  int BIT       = 0,
  localparam int DW        = 2*FRAC_BITS + SQ_W + 2,
  localparam int BW        = FRAC_BITS + SUM_W + 2,
  localparam int YW        = FRAC_BITS + 2,
  localparam int TW        = 2*FRAC_BITS + SUM_W + 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic [SUM_W-1:0]     s_i,
  input  logic [1:0][DW-1:0]   d_i,
  input  logic [1:0][BW-1:0]   b_i,
  input  logic [1:0][YW-1:0]   y_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic [SUM_W-1:0]     s_o,
  output logic [1:0][DW-1:0]   d_o,
  output logic [1:0][BW-1:0]   b_o,
  output logic [1:0][YW-1:0]   y_o
);

  // d holds r - y^2*s, b holds y*s; trial bit t = y + 2^BIT is kept when
  // d >= b*2^(BIT+1) + s*2^(2*BIT)
  logic [1:0][TW-1:0] trial;
  logic [1:0]         take;
  logic [1:0][DW-1:0] d_nxt;
  logic [1:0][BW-1:0] b_nxt;
  logic [1:0][YW-1:0] y_nxt;

  logic               valid_r;
  side_t              side_r;
  logic [SUM_W-1:0]   s_r;
  logic [1:0][DW-1:0] d_r;
  logic [1:0][BW-1:0] b_r;
  logic [1:0][YW-1:0] y_r;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign trial[l] = (TW'(b_i[l]) << (BIT + 1)) + (TW'(s_i) << (2 * BIT));
    assign take[l]  = TW'(d_i[l]) >= trial[l];
    assign d_nxt[l] = take[l] ? (d_i[l] - trial[l][DW-1:0]) : d_i[l];
    assign b_nxt[l] = take[l] ? (b_i[l] + (BW'(s_i) << BIT)) : b_i[l];
    assign y_nxt[l] = y_i[l] | (take[l] ? (YW'(1) << BIT) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_i;
      s_r    <= s_i;
      d_r    <= d_nxt;
      b_r    <= b_nxt;
      y_r    <= y_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign s_o     = s_r;
  assign d_o     = d_r;
  assign b_o     = b_r;
  assign y_o     = y_r;

endmodule

[rtl/core/fln_back.sv]
// output stage: rounding, sign, saturation and the output register
// depends on fln_pkg
module fln_back import fln_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  localparam int YW        = FRAC_BITS + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid_i,
  input  side_t              side_i,
  input  logic [1:0][YW-1:0] y_i,
  output logic               valid_o,
  output out_t               data_o
);

  localparam int QW  = (YW > SUM_W) ? YW : SUM_W;
  localparam int MW  = OUT_W + 1;
  localparam logic [QW-1:0] POS_MAX = QW'(32767);
  localparam logic [QW-1:0] NEG_MAX = QW'(32768);

  logic [1:0][YW:0]      y_inc;
  logic [1:0][QW-1:0]    q;
  logic [1:0][MW-1:0]    mag;
  logic [1:0]            neg;
  logic [1:0][OUT_W-1:0] comp;
  out_t                  out_nxt;

  logic                  valid_r;
  out_t                  out_r;

  assign neg[0] = side_i.neg_x;
  assign neg[1] = side_i.neg_y;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // y = floor(2x), so round-half-away of x is (y + 1) / 2
    assign y_inc[l] = (YW + 1)'(y_i[l]) + (YW + 1)'(1);
    assign q[l]     = QW'(y_inc[l][YW:1]);
    always_comb begin
      if (neg[l]) begin
        mag[l] = (q[l] > NEG_MAX) ? MW'(NEG_MAX) : MW'(q[l]);
      end else begin
        mag[l] = (q[l] > POS_MAX) ? MW'(POS_MAX) : MW'(q[l]);
      end
    end
    assign comp[l] = neg[l] ? OUT_W'(MW'(0) - mag[l]) : OUT_W'(mag[l]);
  end

  always_comb begin
    out_nxt.degenerate = side_i.degen;
    out_nxt.normal_x   = side_i.degen ? '0 : $signed(comp[0]);
    out_nxt.normal_y   = side_i.degen ? '0 : $signed(comp[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = out_r;

endmodule

[rtl/core/four_light_normal_pixel.sv]
// top level of the four-light normal block: front stage, root-search cell chain, output stage
// depends on fln_pkg, fln_front, fln_cell, fln_back and four_light_normal_pixel_macros.svh
//
//   channel   direction  handshake             payload
//   in_*      input      in_valid / in_stall    in_t  (four 24-bit pixels)
//   out_*     output     out_valid / out_stall  out_t (normal_x, normal_y, degenerate)
//
// one pixel transaction per cycle unless the output is valid and stalled; each transaction passes
// through the front stage, FRAC_BITS + 2 search cells and the output register
// each cell settles one bit of the scaled magnitude with one wide compare-subtract per lane
// the whole chain holds while the output is valid and stalled, and in_stall follows
// synchronous active-low reset clears the valid bits only
`include "four_light_normal_pixel_macros.svh"

module four_light_normal_pixel import fln_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int NC = FRAC_BITS + 2;
  localparam int DW = 2*FRAC_BITS + SQ_W + 2;
  localparam int BW = FRAC_BITS + SUM_W + 2;
  localparam int YW = FRAC_BITS + 2;

  logic                 adv;
  logic                 out_zero;

  logic                 front_valid;
  side_t                front_side;
  logic [SUM_W-1:0]     front_s;
  logic [1:0][SQ_W-1:0] front_sq;

  logic                 v_w    [NC+1];
  side_t                side_w [NC+1];
  logic [SUM_W-1:0]     s_w    [NC+1];
  logic [1:0][DW-1:0]   d_w    [NC+1];
  logic [1:0][BW-1:0]   b_w    [NC+1];
  logic [1:0][YW-1:0]   y_w    [NC+1];

  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  fln_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_valid),
    .data_i  (in_data),
    .valid_o (front_valid),
    .side_o  (front_side),
    .s_o     (front_s),
    .sq_o    (front_sq)
  );

  // chain entry: d starts at 4 * mag^2 * 2^(2*FRAC_BITS)
  assign v_w[0]    = front_valid;
  assign side_w[0] = front_side;
  assign s_w[0]    = front_s;
  for (genvar l = 0; l < 2; l++) begin : g_entry
    assign d_w[0][l] = DW'(front_sq[l]) << (2 * FRAC_BITS + 2);
    assign b_w[0][l] = '0;
    assign y_w[0][l] = '0;
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    fln_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (NC - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (v_w[k]),
      .side_i  (side_w[k]),
      .s_i     (s_w[k]),
      .d_i     (d_w[k]),
      .b_i     (b_w[k]),
      .y_i     (y_w[k]),
      .valid_o (v_w[k+1]),
      .side_o  (side_w[k+1]),
      .s_o     (s_w[k+1]),
      .d_o     (d_w[k+1]),
      .b_o     (b_w[k+1]),
      .y_o     (y_w[k+1])
    );
  end

  fln_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (v_w[NC]),
    .side_i  (side_w[NC]),
    .y_i     (y_w[NC]),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  assign out_zero = (out_data.normal_x == '0) && (out_data.normal_y == '0);

  // an undefined normal always comes out as zeros
  `FLN_ASSERT_SAME(a_degen_zero, clk, rst_n, out_valid && out_data.degenerate, out_zero)

  // a defined normal never has both components zero
  `FLN_ASSERT_SAME(a_nonzero, clk, rst_n, out_valid && !out_data.degenerate, !out_zero)

  // an accepted transaction lands in the front stage
  `FLN_ASSERT_NEXT(a_front_load, clk, rst_n, in_valid && !in_stall, front_valid)

endmodule

[tb/sv/four_light_normal_pixel_tb.sv]
// self-checking testbench for four_light_normal_pixel: per-pixel surface normal from four lit images
// depends on fln_pkg and the rtl of four_light_normal_pixel; predicts every normal in place
`timescale 1ns / 1ps

module four_light_normal_pixel_tb;
  import fln_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = FRAC + 4 + 16;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_degen        = 0;
  int n_errors       = 0;

  out_t normal_q[$];

  always #5 clk = ~clk;

  four_light_normal_pixel #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] peak_byte(logic [23:0] p);
    logic [7:0] m;
    m = p[7:0];
    if (p[15:8] > m) m = p[15:8];
    if (p[23:16] > m) m = p[23:16];
    return m;
  endfunction

  // largest q with (2q-1)^2 * sum <= 4 * mag^2 * 2^(2*FRAC), i.e. round half away from zero
  function automatic longint unsigned round_scaled(longint unsigned mag, longint unsigned sum);
    logic [127:0]    rhs;
    logic [127:0]    lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned odd;
    lo  = 0;
    hi  = 64'd1 << FRAC;
    rhs = 128'(mag) * 128'(mag) * 128'd4;
    rhs = rhs << (2 * FRAC);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 2 * mid - 1;
      lhs = 128'(odd) * 128'(odd) * 128'(sum);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [15:0] signed_component(int comp, longint unsigned sum);
    longint unsigned q;
    logic [15:0]     r;
    q = round_scaled((comp < 0) ? -comp : comp, sum);
    if (comp < 0) begin
      if (q > 32768) q = 32768;
      r = q[15:0];
      return -r;
    end
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic out_t predict_normal(in_t px);
    int              dx;
    int              dy;
    longint unsigned sum;
    out_t            r;
    dx  = int'(peak_byte(px.east_pixel)) - int'(peak_byte(px.west_pixel));
    dy  = int'(peak_byte(px.north_pixel)) - int'(peak_byte(px.south_pixel));
    sum = longint'(dx * dx + dy * dy);
    r   = '0;
    if (sum == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.normal_x = signed_component(dx, sum);
      r.normal_y = signed_component(dy, sum);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // pixel whose brightest byte equals peak, placed at a random byte position
  function automatic logic [23:0] pixel_with_peak(logic [7:0] peak);
    logic [23:0] p;
    int          pos;
    pos = $urandom_range(2);
    p   = {8'($urandom_range(peak)), 8'($urandom_range(peak)), 8'($urandom_range(peak))};
    p[pos*8 +: 8] = peak;
    return p;
  endfunction

  function automatic in_t pixels_from_levels(int n, int e, int s, int w);
    in_t px;
    px.north_pixel = pixel_with_peak(8'(n));
    px.east_pixel  = pixel_with_peak(8'(e));
    px.south_pixel = pixel_with_peak(8'(s));
    px.west_pixel  = pixel_with_peak(8'(w));
    return px;
  endfunction

  function automatic int near_level(int base);
    int v;
    v = base + $urandom_range(6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic in_t random_pixels();
    in_t px;
    int  mode;
    int  a;
    int  b;
    mode = $urandom_range(9);
    case (mode)
      0, 1, 2: begin
        px = {24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
      end
      3, 4, 5, 6: begin
        px = pixels_from_levels($urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom_range(255));
      end
      7: begin
        a  = $urandom_range(255);
        b  = $urandom_range(255);
        px = pixels_from_levels(a, b, near_level(a), near_level(b));
      end
      8: begin
        // east matches west and north matches south
        a  = $urandom_range(255);
        b  = $urandom_range(255);
        px = pixels_from_levels(a, b, a, b);
      end
      default: begin
        px = pixels_from_levels(255 * $urandom_range(1), 255 * $urandom_range(1),
                                255 * $urandom_range(1), 255 * $urandom_range(1));
      end
    endcase
    return px;
  endfunction

  // ---------------------------------------------------------------- driver and checker

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= in_t'({24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)});
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    normal_q.push_back(predict_normal(px));
    n_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_t exp_normal;
    if (rst_n && out_valid && !out_stall) begin
      if (normal_q.size() == 0) begin
        $error("unexpected result transaction: normal_x %0d normal_y %0d degenerate %0b",
               out_data.normal_x, out_data.normal_y, out_data.degenerate);
        n_errors++;
      end else begin
        exp_normal = normal_q.pop_front();
        n_checked++;
        if (exp_normal.degenerate) n_degen++;
        if (out_data.normal_x !== exp_normal.normal_x) begin
          $error("normal_x mismatch: expected %0d, actual %0d",
                 exp_normal.normal_x, out_data.normal_x);
          n_errors++;
        end
        if (out_data.normal_y !== exp_normal.normal_y) begin
          $error("normal_y mismatch: expected %0d, actual %0d",
                 exp_normal.normal_y, out_data.normal_y);
          n_errors++;
        end
        if (out_data.degenerate !== exp_normal.degenerate) begin
          $error("degenerate mismatch: expected %0b, actual %0b",
                 exp_normal.degenerate, out_data.degenerate);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_degenerate();
    send_pixel('0);
    send_pixel({4{24'hFFFFFF}});
    send_pixel({24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFF00FF});
    send_pixel({24'h7F0000, 24'h000042, 24'h007F7F, 24'h421042});
    send_pixel(pixels_from_levels(1, 200, 1, 200));
  endtask

  task automatic test_axes();
    send_pixel({24'h000000, 24'h0000FF, 24'h000000, 24'h000000});  // pure east
    send_pixel({24'h000000, 24'h000000, 24'h000000, 24'h00FF00});  // pure west
    send_pixel({24'hFF0000, 24'h000000, 24'h000000, 24'h000000});  // pure north
    send_pixel({24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000});  // pure south
    send_pixel({24'h000000, 24'h000001, 24'h000000, 24'h000000});  // unit step east
    send_pixel({24'h000000, 24'h000000, 24'h010000, 24'h000000});  // unit step south
  endtask

  task automatic test_diagonals();
    send_pixel(pixels_from_levels(255, 255, 0, 0));
    send_pixel(pixels_from_levels(255, 0, 0, 255));
    send_pixel(pixels_from_levels(0, 255, 255, 0));
    send_pixel(pixels_from_levels(0, 0, 255, 255));
    send_pixel(pixels_from_levels(255, 1, 0, 0));
    send_pixel(pixels_from_levels(1, 255, 0, 0));
    send_pixel(pixels_from_levels(0, 0, 255, 1));
    send_pixel(pixels_from_levels(4, 3, 0, 0));
    // brightest byte in each position, in some pixels with the others just below it
    send_pixel({24'h80FF7F, 24'hFE00FF, 24'hFFFEFE, 24'h7F80FE});
    send_pixel({24'h5A5A5B, 24'h00A500, 24'hA5A4A3, 24'h010203});
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_pixel(random_pixels());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_degenerate();
    test_axes();
    test_diagonals();
    test_random(430, 10, 80);
    test_random(430, 80, 10);
    test_random(440, 0, 0);

    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pixel transactions, checked %0d normals (%0d degenerate)",
             n_sent, n_checked, n_degen);
    $display("covered axes, diagonals, unit steps and three idle/stall mixes");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d normals still outstanding", normal_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
